[hw/rtl/bcdalu_pkg.sv]
// ----------------------------------------------------------------------------
// bcdalu_pkg
// Shared types, opcodes and constants of the 8-bit ALU with decimal mode.
// ----------------------------------------------------------------------------
package bcdalu_pkg;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned CMD_W  = 4;

	// operation codes
	typedef enum logic [CMD_W-1:0] {
		CMD_AND = 4'd0,
		CMD_OR  = 4'd1,
		CMD_XOR = 4'd2,
		CMD_BIT = 4'd3,
		CMD_ADC = 4'd4,
		CMD_SBC = 4'd5,
		CMD_CMP = 4'd6,
		CMD_INC = 4'd7,
		CMD_DEC = 4'd8,
		CMD_ASL = 4'd9,
		CMD_ROL = 4'd10,
		CMD_LSR = 4'd11,
		CMD_ROR = 4'd12
	} cmd_t;

	// decimal adjust constants
	localparam logic [4:0] DIGIT_LIMIT  = 5'h0A;
	localparam logic [3:0] DIGIT_ADJUST = 4'h6;
	localparam logic [9:0] BYTE_LIMIT   = 10'h0A0;
	localparam logic [9:0] BYTE_ADJUST  = 10'h060;

	// one operation as it enters the datapath
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] reg_value;
		logic [DATA_W-1:0] operand;
		logic              carry_in;
		logic              overflow_in;
		logic              bcd_enable;
	} alu_in_t;

	// one result with its flags
	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              negative;
		logic              overflow_out;
		logic              zero;
		logic              carry_out;
	} alu_out_t;

	// signed overflow from the sign bits of both operands and of the sum
	function automatic logic sgn_ovf(input logic s1, input logic s2, input logic sr);
		return (s1 & s2 & ~sr) | (~s1 & ~s2 & sr);
	endfunction

endpackage

[hw/rtl/eight_bit_bcd_alu.sv]
// ----------------------------------------------------------------------------
// eight_bit_bcd_alu
// 8-bit processor ALU with decimal mode, two register stages.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | cmd, reg_value, operand, carry_in,
//          |                    | overflow_in, bcd_enable
//  out     | out_valid/out_ready| result, negative, overflow_out, zero,
//          |                    | carry_out
//
// One operation per cycle while out_ready does not stall the result; an
// accepted operation goes through the input register, the datapath and the
// result register before its output transfer.
// Reset clears both valid bits; payload registers are not reset.
// A stalled result holds the result register; the input register still
// takes a new operation while it is empty or its content moves on.
// ----------------------------------------------------------------------------
module eight_bit_bcd_alu (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] cmd,
	input  logic [7:0] reg_value,
	input  logic [7:0] operand,
	input  logic       carry_in,
	input  logic       overflow_in,
	input  logic       bcd_enable,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result,
	output logic       negative,
	output logic       overflow_out,
	output logic       zero,
	output logic       carry_out
);

	bcdalu_pkg::alu_in_t  item_s1;
	logic                 valid_s1;
	bcdalu_pkg::alu_out_t alu_res;
	bcdalu_pkg::alu_out_t res_s2;
	logic                 valid_s2;
	logic                 adv_s2;
	logic                 adv_s1;

	// stage advance conditions
	assign adv_s2   = ~valid_s2 | out_ready;
	assign adv_s1   = ~valid_s1 | adv_s2;
	assign in_ready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1.cmd          <= cmd;
			item_s1.reg_value    <= reg_value;
			item_s1.operand      <= operand;
			item_s1.carry_in     <= carry_in;
			item_s1.overflow_in  <= overflow_in;
			item_s1.bcd_enable   <= bcd_enable;
		end
	end

	// datapath
	bcdalu_core u_core (
		.op_in  (item_s1),
		.op_out (alu_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= alu_res;
		end
	end

	assign out_valid    = valid_s2;
	assign result       = res_s2.result;
	assign negative     = res_s2.negative;
	assign overflow_out = res_s2.overflow_out;
	assign zero         = res_s2.zero;
	assign carry_out    = res_s2.carry_out;

endmodule

[hw/rtl/bcdalu_core.sv]
// ----------------------------------------------------------------------------
// bcdalu_core
// Combinational datapath: logic, binary and decimal add/subtract, compare,
// increment, decrement and shifts, with the N, V, Z and C flags.
// ----------------------------------------------------------------------------
module bcdalu_core (
	input  bcdalu_pkg::alu_in_t  op_in,
	output bcdalu_pkg::alu_out_t op_out
);

	logic [7:0] a;
	logic [7:0] b;
	logic       c;
	bcdalu_pkg::cmd_t op;

	logic [8:0] bin_add;
	logic [8:0] bin_sub;
	logic [8:0] cmp_diff;

	logic [4:0] lo_add;
	logic [4:0] lo_add_fix;
	logic [9:0] hi_add;
	logic [9:0] dec_add;

	logic [5:0] lo_sub;
	logic [5:0] lo_sub_fix;
	logic [9:0] hi_sub;
	logic [9:0] dec_sub;

	logic [7:0] res;
	logic       n_flag;
	logic       v_flag;
	logic       z_flag;
	logic       c_flag;
	logic       nz_from_res;

	assign a  = op_in.reg_value;
	assign b  = op_in.operand;
	assign c  = op_in.carry_in;
	assign op = bcdalu_pkg::cmd_t'(op_in.cmd);

	// binary adders and compare
	assign bin_add  = {1'b0, a} + {1'b0, b} + {8'd0, c};
	assign bin_sub  = {1'b0, a} + {1'b0, ~b} + {8'd0, c};
	assign cmp_diff = {1'b0, a} - {1'b0, b};

	// decimal add: low digit then high digit, each with its adjust
	assign lo_add     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
	assign lo_add_fix = (lo_add >= bcdalu_pkg::DIGIT_LIMIT)
		? {1'b1, lo_add[3:0] + bcdalu_pkg::DIGIT_ADJUST} : lo_add;
	assign hi_add     = {2'b00, a[7:4], 4'd0} + {2'b00, b[7:4], 4'd0} + {5'd0, lo_add_fix};
	assign dec_add    = (hi_add >= bcdalu_pkg::BYTE_LIMIT)
		? hi_add + bcdalu_pkg::BYTE_ADJUST : hi_add;

	// decimal subtract, signed intermediates in two's complement
	assign lo_sub     = {2'b00, a[3:0]} - {2'b00, b[3:0]} + {5'd0, c} - 6'd1;
	assign lo_sub_fix = lo_sub[5]
		? {2'b11, lo_sub[3:0] - bcdalu_pkg::DIGIT_ADJUST} : lo_sub;
	assign hi_sub     = {2'b00, a[7:4], 4'd0} - {2'b00, b[7:4], 4'd0}
		+ {{4{lo_sub_fix[5]}}, lo_sub_fix};
	assign dec_sub    = hi_sub[9] ? hi_sub - bcdalu_pkg::BYTE_ADJUST : hi_sub;

	// operation select; untouched flags pass through
	always_comb begin
		res         = a;
		n_flag      = 1'b0;
		z_flag      = 1'b0;
		v_flag      = op_in.overflow_in;
		c_flag      = c;
		nz_from_res = 1'b1;
		unique case (op)
			bcdalu_pkg::CMD_AND: res = a & b;
			bcdalu_pkg::CMD_OR:  res = a | b;
			bcdalu_pkg::CMD_XOR: res = a ^ b;
			bcdalu_pkg::CMD_BIT: begin
				n_flag      = b[7];
				v_flag      = b[6];
				z_flag      = ((a & b) == 8'd0);
				nz_from_res = 1'b0;
			end
			bcdalu_pkg::CMD_ADC: begin
				if (op_in.bcd_enable) begin
					res    = dec_add[7:0];
					v_flag = bcdalu_pkg::sgn_ovf(a[7], b[7], dec_add[7]);
					c_flag = dec_add[9] | dec_add[8];
				end else begin
					res    = bin_add[7:0];
					v_flag = bcdalu_pkg::sgn_ovf(a[7], b[7], bin_add[7]);
					c_flag = bin_add[8];
				end
			end
			bcdalu_pkg::CMD_SBC: begin
				c_flag = bin_sub[8];
				if (op_in.bcd_enable) begin
					res    = dec_sub[7:0];
					v_flag = bcdalu_pkg::sgn_ovf(a[7], ~b[7], dec_sub[7]);
				end else begin
					res    = bin_sub[7:0];
					v_flag = bcdalu_pkg::sgn_ovf(a[7], ~b[7], bin_sub[7]);
				end
			end
			bcdalu_pkg::CMD_CMP: begin
				n_flag      = cmp_diff[7];
				z_flag      = (cmp_diff[7:0] == 8'd0);
				c_flag      = ~cmp_diff[8];
				nz_from_res = 1'b0;
			end
			bcdalu_pkg::CMD_INC: res = b + 8'd1;
			bcdalu_pkg::CMD_DEC: res = b - 8'd1;
			bcdalu_pkg::CMD_ASL: begin
				res    = {b[6:0], 1'b0};
				c_flag = b[7];
			end
			bcdalu_pkg::CMD_ROL: begin
				res    = {b[6:0], c};
				c_flag = b[7];
			end
			bcdalu_pkg::CMD_LSR: begin
				res    = {1'b0, b[7:1]};
				c_flag = b[0];
			end
			bcdalu_pkg::CMD_ROR: begin
				res    = {c, b[7:1]};
				c_flag = b[0];
			end
			default: res = a;
		endcase
		if (nz_from_res) begin
			n_flag = res[7];
			z_flag = (res == 8'd0);
		end
	end

	assign op_out.result       = res;
	assign op_out.negative     = n_flag;
	assign op_out.overflow_out = v_flag;
	assign op_out.zero         = z_flag;
	assign op_out.carry_out    = c_flag;

endmodule
